/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the checker file dlec_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// clocked assertion, also checked during reset
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

/* rtl/dlec_pkg.sv */
// ----------------------------------------------------------------------------
// dlec_pkg
// shared types and constants of the debounced led effect cycler
// ----------------------------------------------------------------------------
package dlec_pkg;

   localparam logic CSR_DEBOUNCE = 1'b0;
   localparam logic CSR_FRAME    = 1'b1;

   localparam logic [7:0] DEBOUNCE_RESET = 8'd3;
   localparam logic [7:0] FRAME_RESET    = 8'd2;

   localparam logic [7:0]  SEG_ONE      = 8'd85;
   localparam logic [7:0]  SEG_TWO      = 8'd170;
   localparam logic [7:0]  TRI_HALF     = 8'd128;
   localparam logic [7:0]  FULL_LEVEL   = 8'd255;
   localparam logic [11:0] BREATHE_DIV  = 12'd127;
   localparam logic [7:0]  FLASH_LEVEL  = 8'd32;
   // floor(p / 12) = (p * 171) >> 11 for any 8-bit p
   localparam logic [7:0]  FLASH_RECIP  = 8'd171;
   localparam int          FLASH_SHIFT  = 11;

   typedef enum logic [1:0] {
      MODE_OFF     = 2'd0,
      MODE_RAINBOW = 2'd1,
      MODE_BREATHE = 2'd2,
      MODE_FLASH   = 2'd3
   } mode_type;

   typedef struct packed {
      logic [7:0] debounce;
      logic [7:0] frame;
   } cfg_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [1:0] mode;
   } colour_type;

   typedef struct packed {
      logic       emit;
      colour_type colour;
   } result_type;

endpackage

/* rtl/dlec_req_if.sv */
// ----------------------------------------------------------------------------
// dlec_req_if
// button sample channel: valid, ready and the raw button level
// ----------------------------------------------------------------------------
interface dlec_req_if;
   logic valid;
   logic ready;
   logic button_raw;

   modport source (output valid, output button_raw, input ready);
   modport sink   (input valid, input button_raw, output ready);
endinterface

/* rtl/dlec_rsp_if.sv */
// ----------------------------------------------------------------------------
// dlec_rsp_if
// color result channel: valid, ready, rgb levels and effect mode
// ----------------------------------------------------------------------------
interface dlec_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_level;
   logic [7:0] green_level;
   logic [7:0] blue_level;
   logic [1:0] effect_mode;

   modport source (output valid, output red_level, output green_level,
                   output blue_level, output effect_mode, input ready);
   modport sink   (input valid, input red_level, input green_level,
                   input blue_level, input effect_mode, output ready);
endinterface

/* rtl/dlec_colour.sv */
// ----------------------------------------------------------------------------
// dlec_colour
// maps effect mode and phase to an rgb color
// ----------------------------------------------------------------------------
module dlec_colour (
   input  logic [1:0]          mode,
   input  logic [7:0]          phase,
   output dlec_pkg::colour_type colour
);

   logic [7:0]  seg_x;
   logic [7:0]  rise;
   logic [7:0]  fall;
   logic [6:0]  tri_val;
   logic [11:0] scaled;
   logic [4:0]  q_est;
   logic [11:0] q_prod;
   logic [11:0] q_rem;
   logic [5:0]  q_fix;
   logic [15:0] flash_prod;

   always_comb begin
      if (phase < dlec_pkg::SEG_ONE) begin
         seg_x = phase;
      end else if (phase < dlec_pkg::SEG_TWO) begin
         seg_x = phase - dlec_pkg::SEG_ONE;
      end else begin
         seg_x = phase - dlec_pkg::SEG_TWO;
      end
      rise = 8'({seg_x, 1'b0} + {1'b0, seg_x});
      fall = dlec_pkg::FULL_LEVEL - rise;

      tri_val = (phase < dlec_pkg::TRI_HALF) ? phase[6:0]
                                             : 7'(dlec_pkg::FULL_LEVEL - phase);
      scaled  = {tri_val, 5'b0};
      q_est   = scaled[11:7];
      q_prod  = {q_est, 7'b0} - {7'b0, q_est};
      q_rem   = scaled - q_prod;
      q_fix   = (q_rem >= dlec_pkg::BREATHE_DIV) ? ({1'b0, q_est} + 6'd1)
                                                 : {1'b0, q_est};

      flash_prod = {8'b0, phase} * {8'b0, dlec_pkg::FLASH_RECIP};

      colour      = '0;
      colour.mode = mode;
      case (dlec_pkg::mode_type'(mode))
         dlec_pkg::MODE_RAINBOW: begin
            if (phase < dlec_pkg::SEG_ONE) begin
               colour.red   = {3'b0, fall[7:3]};
               colour.green = {3'b0, rise[7:3]};
            end else if (phase < dlec_pkg::SEG_TWO) begin
               colour.green = {3'b0, fall[7:3]};
               colour.blue  = {3'b0, rise[7:3]};
            end else begin
               colour.red   = {3'b0, rise[7:3]};
               colour.blue  = {3'b0, fall[7:3]};
            end
         end
         dlec_pkg::MODE_BREATHE: begin
            colour.blue = {2'b0, q_fix};
         end
         dlec_pkg::MODE_FLASH: begin
            if (!flash_prod[dlec_pkg::FLASH_SHIFT]) begin
               colour.red = dlec_pkg::FLASH_LEVEL;
            end else begin
               colour.blue = dlec_pkg::FLASH_LEVEL;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

/* rtl/dlec_core.sv */
// ----------------------------------------------------------------------------
// dlec_core
// debounce, mode stepping and frame timing state, one sample per step
// ----------------------------------------------------------------------------
module dlec_core #(
   parameter int AGE_WIDTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 raw,
   input  dlec_pkg::cfg_type    cfg,
   output dlec_pkg::result_type result
);

   localparam int CMP_W = (AGE_WIDTH > 8) ? AGE_WIDTH : 8;
   localparam logic [AGE_WIDTH-1:0] AGE_MAX = '1;

   logic                 stable_ff, stable_in;
   logic                 cand_ff, cand_in;
   logic [AGE_WIDTH-1:0] cage_ff, cage_in;
   logic [1:0]           mode_ff, mode_in;
   logic [7:0]           phase_ff, phase_in;
   logic [AGE_WIDTH-1:0] fage_ff, fage_in;

   logic                 level_change;
   logic                 settle;
   logic                 press;
   logic                 frame;
   logic [7:0]           fthr;
   logic [AGE_WIDTH-1:0] cage_cur;
   logic [AGE_WIDTH-1:0] fage_cur;
   dlec_pkg::colour_type colour;

   always_comb begin
      level_change = (raw != cand_ff);
      settle = !level_change && (cand_ff != stable_ff)
               && (CMP_W'(cage_ff) >= CMP_W'(cfg.debounce));
      press  = settle && !cand_ff;
      fthr   = (cfg.frame == 8'd0) ? 8'd1 : cfg.frame;
      frame  = !press && (CMP_W'(fage_ff) >= CMP_W'(fthr));

      cage_cur  = level_change ? '0 : cage_ff;
      fage_cur  = (press || frame) ? '0 : fage_ff;
      cage_in   = (cage_cur == AGE_MAX) ? cage_cur : cage_cur + AGE_WIDTH'(1);
      fage_in   = (fage_cur == AGE_MAX) ? fage_cur : fage_cur + AGE_WIDTH'(1);
      cand_in   = raw;
      stable_in = settle ? cand_ff : stable_ff;
      mode_in   = press ? mode_ff + 2'd1 : mode_ff;
      if (press) begin
         phase_in = 8'd0;
      end else if (frame) begin
         phase_in = phase_ff + 8'd1;
      end else begin
         phase_in = phase_ff;
      end
   end

   dlec_colour u_colour (
      .mode   (mode_in),
      .phase  (phase_in),
      .colour (colour)
   );

   always_comb begin
      result.emit   = press || frame;
      result.colour = colour;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= 1'b1;
         cand_ff   <= 1'b1;
         cage_ff   <= '0;
         mode_ff   <= dlec_pkg::MODE_OFF;
         phase_ff  <= 8'd0;
         fage_ff   <= '0;
      end else if (step) begin
         stable_ff <= stable_in;
         cand_ff   <= cand_in;
         cage_ff   <= cage_in;
         mode_ff   <= mode_in;
         phase_ff  <= phase_in;
         fage_ff   <= fage_in;
      end
   end

endmodule

/* rtl/debounced_led_effect_cycler.sv */
// ----------------------------------------------------------------------------
// debounced_led_effect_cycler
// debounces an active-low button and cycles rgb led effects
// ----------------------------------------------------------------------------
// usage:
//   req_ch carries one button poll sample per transaction (0 = pressed).
//   rsp_ch carries a color and the effect mode, produced only on a debounced
//   press or a frame tick; other samples yield no transaction.
//   csr_* writes debounce_samples (index 0) and frame_samples (index 1);
//   the user writes only while the block is idle; the block does not enforce it.
// timing:
//   one sample per cycle sustained while rsp_ch is not stalled; a sample is
//   held in the input register, then the state update and color logic load
//   the output register, which drives the result on rsp_ch until it is taken.
// reset:
//   synchronous; clears the valid flags of both pipeline registers, the
//   debounce and effect state, and restores the register defaults (3 and 2).
// stall:
//   while rsp_ch is stalled holding a result, the input register still
//   takes one more sample; after that req_ch.ready drops until the output
//   register frees.
// ----------------------------------------------------------------------------
module debounced_led_effect_cycler #(
   parameter int AGE_WIDTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   dlec_req_if.sink   req_ch,
   dlec_rsp_if.source rsp_ch,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [7:0] csr_write_data
);

   logic                 in_valid_ff, in_valid_in;
   logic                 in_raw_ff;
   logic                 out_valid_ff, out_valid_in;
   dlec_pkg::colour_type out_colour_ff;
   dlec_pkg::cfg_type    cfg_ff;
   dlec_pkg::result_type result;
   logic                 out_free;
   logic                 step;

   always_comb begin
      out_free     = !out_valid_ff || rsp_ch.ready;
      step         = in_valid_ff && out_free;
      req_ch.ready = !in_valid_ff || out_free;
      if (req_ch.valid && req_ch.ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      out_valid_in = out_free ? (step && result.emit) : out_valid_ff;
   end

   dlec_core #(
      .AGE_WIDTH (AGE_WIDTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .raw    (in_raw_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_raw_ff <= req_ch.button_raw;
      end
      if (step && result.emit) begin
         out_colour_ff <= result.colour;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce <= dlec_pkg::DEBOUNCE_RESET;
         cfg_ff.frame    <= dlec_pkg::FRAME_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            dlec_pkg::CSR_DEBOUNCE: cfg_ff.debounce <= csr_write_data;
            dlec_pkg::CSR_FRAME:    cfg_ff.frame    <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.red_level   = out_colour_ff.red;
   assign rsp_ch.green_level = out_colour_ff.green;
   assign rsp_ch.blue_level  = out_colour_ff.blue;
   assign rsp_ch.effect_mode = out_colour_ff.mode;

endmodule

/* rtl/dlec_checker.sv */
// ----------------------------------------------------------------------------
// dlec_checker
// port-level checks of the effect cycler, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dlec_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] red_level,
   input logic [7:0] green_level,
   input logic [7:0] blue_level,
   input logic [1:0] effect_mode
);

   `ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid)

   `ASSERT_CLK(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)

   `ASSERT_CLK(a_off_is_dark, clock, reset,
      rsp_valid && effect_mode == dlec_pkg::MODE_OFF |->
      red_level == 8'd0 && green_level == 8'd0 && blue_level == 8'd0)

   `ASSERT_CLK(a_breathe_blue_only, clock, reset,
      rsp_valid && effect_mode == dlec_pkg::MODE_BREATHE |->
      red_level == 8'd0 && green_level == 8'd0 && blue_level <= dlec_pkg::FLASH_LEVEL)

   `ASSERT_CLK(a_flash_one_colour, clock, reset,
      rsp_valid && effect_mode == dlec_pkg::MODE_FLASH |-> green_level == 8'd0 &&
      ((red_level == dlec_pkg::FLASH_LEVEL && blue_level == 8'd0) ||
       (red_level == 8'd0 && blue_level == dlec_pkg::FLASH_LEVEL)))

endmodule

bind debounced_led_effect_cycler dlec_checker u_dlec_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .red_level   (rsp_ch.red_level),
   .green_level (rsp_ch.green_level),
   .blue_level  (rsp_ch.blue_level),
   .effect_mode (rsp_ch.effect_mode)
);
